// ----- design/assert_macros.svh -----
// assertion macros shared by the occupancy grid design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ogp_pkg.sv -----
// types, constants and sizes shared by the occupancy grid to points design
package ogp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int GW_W       = 13;
    localparam int RES_W      = 24;
    localparam int COORD_W    = 32;
    localparam int QUAT_W     = 64;
    localparam int Q_W        = 16;
    localparam int CELL_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int P_W        = ((COL_W > ROW_W) ? COL_W : ROW_W) + RES_W;
    localparam int LO_W       = 18;
    localparam int HI_W       = P_W - LO_W;
    localparam int B_W        = ((HI_W > LO_W) ? HI_W : LO_W) + 1;
    localparam int M_W        = 34;
    localparam int PR_W       = M_W + B_W;
    localparam int ACC_W      = M_W + P_W + 2;
    localparam int FRAC_SHIFT = 28;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int SUM_W      = RND_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic [GW_W-1:0]   GW_RESET   = GW_W'(4096);
    localparam logic [RES_W-1:0]  RES_RESET  = RES_W'(3277);
    localparam logic [QUAT_W-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;

    localparam logic signed [M_W-1:0]   M_ONE    = M_W'(1) << FRAC_SHIFT;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH = 3'd0,
        CFG_CELL_RES   = 3'd1,
        CFG_ORIGIN_X   = 3'd2,
        CFG_ORIGIN_Y   = 3'd3,
        CFG_ORIGIN_Z   = 3'd4,
        CFG_ORIENT     = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MAT0,
        B_MAT1,
        B_MAT2,
        B_MAT3,
        B_POS,
        B_MAC0,
        B_MAC1,
        B_MAC2,
        B_MAC3,
        B_RND,
        B_FIN
    } t_bstate;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic                     last_cell;
    } t_cell;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      point_valid;
        logic                      end_of_grid;
    } t_point;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             is_free;
        logic             is_last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [RES_W-1:0]            cell_res;
        logic [2:0][COORD_W-1:0]     origin;
        logic [QUAT_W-1:0]           quat;
    } t_geom;

endpackage

// ----- design/occupancy_grid_to_points.sv -----
// top level of the occupancy grid to points block: configuration registers and wiring
// throughput: cells that give no point go at one a cycle unless the queue is full; each free
//   cell holds the point unit through position, four multiply-accumulate steps per axis,
//   round and offset
// the four-entry queue lets the front take cells while the point unit works
// reset: synchronous active low; the rotation matrix is rebuilt (MAT0 to MAT3) after reset
//   and after every orientation write, before the next point is started
module occupancy_grid_to_points
    import ogp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_cell                 i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_point                o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GW_W-1:0]         r_grid_width, n_grid_width;
    logic [RES_W-1:0]        r_cell_res, n_cell_res;
    logic [2:0][COORD_W-1:0] r_origin, n_origin;
    logic [QUAT_W-1:0]       r_quat, n_quat;

    logic    cfg_wr;
    logic    quat_wr;
    t_geom   geom;
    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_grid_width = r_grid_width;
        n_cell_res   = r_cell_res;
        n_origin     = r_origin;
        n_quat       = r_quat;
        quat_wr      = 1'b0;
        if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_WIDTH: n_grid_width = i_cfg_data[GW_W-1:0];
                CFG_CELL_RES:   n_cell_res   = i_cfg_data[RES_W-1:0];
                CFG_ORIGIN_X:   n_origin[0]  = i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:   n_origin[1]  = i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Z:   n_origin[2]  = i_cfg_data[COORD_W-1:0];
                CFG_ORIENT: begin
                    n_quat  = i_cfg_data[QUAT_W-1:0];
                    quat_wr = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GW_RESET;
            r_cell_res   <= RES_RESET;
            r_origin     <= '0;
            r_quat       <= QUAT_RESET;
        end else begin
            r_grid_width <= n_grid_width;
            r_cell_res   <= n_cell_res;
            r_origin     <= n_origin;
            r_quat       <= n_quat;
        end
    end

    always_comb begin
        geom.cell_res = r_cell_res;
        geom.origin   = r_origin;
        geom.quat     = r_quat;
    end

    ogp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_grid_width (r_grid_width),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_job        (push_job)
    );

    ogp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    ogp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_quat_wr   (quat_wr),
        .i_q_stat    (q_stat),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- design/ogp_front.sv -----
// front end: takes cells, tracks column and row, queues cells that give a result
module ogp_front
    import ogp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  t_cell           i_in_data,
    output logic            o_in_stall,
    input  logic [GW_W-1:0] i_grid_width,
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output t_job            o_job
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;
    logic             is_free;
    logic [GW_W-1:0]  eff_w;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;
    assign is_free    = (i_in_data.cell_value == '0);
    assign col_inc    = {1'b0, r_col} + (COL_W+1)'(1);
    assign row_inc    = {1'b0, r_row} + (ROW_W+1)'(1);

    always_comb begin
        if (i_grid_width == '0) begin
            eff_w = GW_W'(1);
        end else if (32'(i_grid_width) > 32'(MAX_WIDTH)) begin
            eff_w = GW_W'(MAX_WIDTH);
        end else begin
            eff_w = i_grid_width;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_in_data.last_cell) begin
                n_col = '0;
                n_row = '0;
            end else if (32'(col_inc) >= 32'(eff_w)) begin
                n_col = '0;
                if (32'(row_inc) >= 32'(MAX_HEIGHT)) begin
                    n_row = '0;
                end else begin
                    n_row = row_inc[ROW_W-1:0];
                end
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb begin
        o_push        = accept && (is_free || i_in_data.last_cell);
        o_job.col     = r_col;
        o_job.row     = r_row;
        o_job.is_free = is_free;
        o_job.is_last = i_in_data.last_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_in_data.last_cell, (r_col == '0) && (r_row == '0), "counters not cleared after last cell")

endmodule

// ----- design/ogp_queue.sv -----
// short request queue between the front end and the point unit
module ogp_queue
    import ogp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr, n_wr;
    logic [QA_W-1:0] r_rd, n_rd;
    logic [QA_W:0]   r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QA_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QA_W+1)'(1);
        end
    end

    always_comb begin
        o_job        = r_mem[r_rd];
        o_stat.full  = (r_count == (QA_W+1)'(QUEUE_DEPTH));
        o_stat.empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && o_stat.empty), "pop from empty queue")
    `ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(i_push && o_stat.full), "push into full queue")

endmodule

// ----- design/ogp_back.sv -----
// point unit: rotation matrix, position, rotate, round, offset and saturate
module ogp_back
    import ogp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_geom   i_geom,
    input  logic    i_quat_wr,
    input  t_q_stat i_q_stat,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_out_valid,
    output t_point  o_out_data,
    input  logic    i_out_stall
);

    t_bstate r_state, n_state;
    logic    r_dirty, n_dirty;
    t_job    r_job, n_job;
    logic    r_out_valid, n_out_valid;
    t_point  r_out, n_out;

    logic signed [2*Q_W-1:0] r_qp  [9];
    logic signed [2*Q_W-1:0] n_qp  [9];
    logic signed [M_W-1:0]   r_ma  [3];
    logic signed [M_W-1:0]   n_ma  [3];
    logic signed [M_W-1:0]   r_mb  [3];
    logic signed [M_W-1:0]   n_mb  [3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [ACC_W-1:0] n_acc [3];
    logic signed [RND_W-1:0] r_rnd [3];
    logic signed [RND_W-1:0] n_rnd [3];
    logic [P_W-1:0]          r_px, n_px;
    logic [P_W-1:0]          r_py, n_py;

    logic signed [M_W-1:0]   mul_a [3];
    logic signed [B_W-1:0]   mul_b [3];
    logic signed [PR_W-1:0]  prod  [3];
    logic signed [ACC_W-1:0] rnd_sum [3];
    logic signed [SUM_W-1:0] off_sum [3];
    logic [COORD_W-1:0]      coord [3];

    logic signed [Q_W-1:0] qw, qx, qy, qz;
    logic                  slot_free;
    logic                  start;

    assign qw = i_geom.quat[4*Q_W-1:3*Q_W];
    assign qx = i_geom.quat[3*Q_W-1:2*Q_W];
    assign qy = i_geom.quat[2*Q_W-1:Q_W];
    assign qz = i_geom.quat[Q_W-1:0];

    assign slot_free = !r_out_valid || !i_out_stall;
    assign start     = (r_state == B_IDLE) && !r_dirty && !i_q_stat.empty;

    // operand selection for the three multiplier lanes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (r_state)
            B_MAT0: begin
                mul_a[0] = M_W'(qy); mul_b[0] = B_W'(qy);
                mul_a[1] = M_W'(qz); mul_b[1] = B_W'(qz);
                mul_a[2] = M_W'(qx); mul_b[2] = B_W'(qx);
            end
            B_MAT1: begin
                mul_a[0] = M_W'(qx); mul_b[0] = B_W'(qy);
                mul_a[1] = M_W'(qw); mul_b[1] = B_W'(qz);
                mul_a[2] = M_W'(qx); mul_b[2] = B_W'(qz);
            end
            B_MAT2: begin
                mul_a[0] = M_W'(qw); mul_b[0] = B_W'(qy);
                mul_a[1] = M_W'(qy); mul_b[1] = B_W'(qz);
                mul_a[2] = M_W'(qw); mul_b[2] = B_W'(qx);
            end
            B_POS: begin
                mul_a[0] = M_W'(i_geom.cell_res); mul_b[0] = B_W'(r_job.col);
                mul_a[1] = M_W'(i_geom.cell_res); mul_b[1] = B_W'(r_job.row);
            end
            B_MAC0: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = r_ma[i];
                    mul_b[i] = B_W'(r_px[P_W-1:LO_W]);
                end
            end
            B_MAC1: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = r_mb[i];
                    mul_b[i] = B_W'(r_py[P_W-1:LO_W]);
                end
            end
            B_MAC2: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = r_ma[i];
                    mul_b[i] = B_W'(r_px[LO_W-1:0]);
                end
            end
            B_MAC3: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = r_mb[i];
                    mul_b[i] = B_W'(r_py[LO_W-1:0]);
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            prod[i] = mul_a[i] * mul_b[i];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (r_dirty) begin
                    n_state = B_MAT0;
                end else if (!i_q_stat.empty) begin
                    n_state = i_job.is_free ? B_POS : B_FIN;
                end
            end
            B_MAT0:  n_state = B_MAT1;
            B_MAT1:  n_state = B_MAT2;
            B_MAT2:  n_state = B_MAT3;
            B_MAT3:  n_state = B_IDLE;
            B_POS:   n_state = B_MAC0;
            B_MAC0:  n_state = B_MAC1;
            B_MAC1:  n_state = B_MAC2;
            B_MAC2:  n_state = B_MAC3;
            B_MAC3:  n_state = B_RND;
            B_RND:   n_state = B_FIN;
            B_FIN: begin
                if (slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop       = start;
        n_job       = start ? i_job : r_job;
        n_dirty     = i_quat_wr ? 1'b1 : ((r_state == B_MAT0) ? 1'b0 : r_dirty);
        n_qp        = r_qp;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_acc       = r_acc;
        n_rnd       = r_rnd;
        n_px        = r_px;
        n_py        = r_py;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        for (int i = 0; i < 3; i++) begin
            rnd_sum[i] = r_acc[i] + RND_HALF;
            off_sum[i] = SUM_W'(r_rnd[i]) + SUM_W'($signed(i_geom.origin[i]));
            if (off_sum[i][SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){off_sum[i][SUM_W-1]}}) begin
                coord[i] = off_sum[i][SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                               : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                coord[i] = off_sum[i][COORD_W-1:0];
            end
        end

        case (r_state)
            B_MAT0: begin
                n_qp[0] = prod[0][2*Q_W-1:0];
                n_qp[1] = prod[1][2*Q_W-1:0];
                n_qp[2] = prod[2][2*Q_W-1:0];
            end
            B_MAT1: begin
                n_qp[3] = prod[0][2*Q_W-1:0];
                n_qp[4] = prod[1][2*Q_W-1:0];
                n_qp[5] = prod[2][2*Q_W-1:0];
            end
            B_MAT2: begin
                n_qp[6] = prod[0][2*Q_W-1:0];
                n_qp[7] = prod[1][2*Q_W-1:0];
                n_qp[8] = prod[2][2*Q_W-1:0];
            end
            B_MAT3: begin
                // qp: yy zz xx xy wz xz wy yz wx
                n_ma[0] = M_ONE - ((M_W'(r_qp[0]) + M_W'(r_qp[1])) <<< 1);
                n_mb[0] = (M_W'(r_qp[3]) - M_W'(r_qp[4])) <<< 1;
                n_ma[1] = (M_W'(r_qp[3]) + M_W'(r_qp[4])) <<< 1;
                n_mb[1] = M_ONE - ((M_W'(r_qp[2]) + M_W'(r_qp[1])) <<< 1);
                n_ma[2] = (M_W'(r_qp[5]) - M_W'(r_qp[6])) <<< 1;
                n_mb[2] = (M_W'(r_qp[7]) + M_W'(r_qp[8])) <<< 1;
            end
            B_POS: begin
                n_px = prod[0][P_W-1:0];
                n_py = prod[1][P_W-1:0];
            end
            B_MAC0: begin
                for (int i = 0; i < 3; i++) begin
                    n_acc[i] = ACC_W'(prod[i]);
                end
            end
            B_MAC1, B_MAC3: begin
                for (int i = 0; i < 3; i++) begin
                    n_acc[i] = r_acc[i] + ACC_W'(prod[i]);
                end
            end
            B_MAC2: begin
                for (int i = 0; i < 3; i++) begin
                    n_acc[i] = (r_acc[i] <<< LO_W) + ACC_W'(prod[i]);
                end
            end
            B_RND: begin
                for (int i = 0; i < 3; i++) begin
                    n_rnd[i] = RND_W'(rnd_sum[i] >>> FRAC_SHIFT);
                end
            end
            default: begin
            end
        endcase

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == B_FIN) && slot_free) begin
            n_out_valid       = 1'b1;
            n_out.point_valid = r_job.is_free;
            n_out.end_of_grid = r_job.is_last;
            if (r_job.is_free) begin
                n_out.point_x = coord[0];
                n_out.point_y = coord[1];
                n_out.point_z = coord[2];
            end else begin
                n_out.point_x = '0;
                n_out.point_y = '0;
                n_out.point_z = '0;
            end
        end

        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_qp  <= n_qp;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_acc <= n_acc;
        r_rnd <= n_rnd;
        r_px  <= n_px;
        r_py  <= n_py;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_matrix_fresh, i_clk, i_rst_n, r_state == B_POS, !r_dirty, "matrix stale at position step")
    `ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, (r_state == B_FIN) && !r_job.is_free, r_job.is_last, "occupied cell reached output without last mark")

endmodule
